[rtl/fwd_pkg.sv]
// ----------------------------------------------------------------------------
// fwd_pkg
// Shared codes, field widths and sequencer state type for the ordered tag
// queue with delete by value.
// ----------------------------------------------------------------------------
package fwd_pkg;

   localparam int KIND_WIDTH    = 2;
   localparam int TAG_IO_WIDTH  = 32;
   localparam int COUNT_WIDTH   = 5;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 40;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_DEQUEUE = 2'd1,
      KIND_DELETE  = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DECODE   = 7'b0000010,
      ST_FRONT    = 7'b0000100,
      ST_SCAN     = 7'b0001000,
      ST_SHIFT_RD = 7'b0010000,
      ST_SHIFT_WR = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

endpackage

[rtl/fwd_tag_ram.sv]
// ----------------------------------------------------------------------------
// fwd_tag_ram
// Tag storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fwd_tag_ram #(
   parameter int DEPTH      = 16,
   parameter int WIDTH      = 32,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fifo_with_delete_by_value_unit.sv]
// ----------------------------------------------------------------------------
// Sequence: enqueue and early rejects go from decode straight to the result
// stage; dequeue reads the front entry, then moves each later entry down one
// slot; delete scans for the first match and on a hit moves the later ones down.
// One beat at a time: req_tready is high only while idle, so the next beat can
// be taken in the cycle after the result register is loaded.
// Reset (synchronous, active high) empties the queue; ram contents stay.
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value_unit
// Ordered queue of nonzero tags with enqueue, dequeue and delete of the first
// matching entry; a small sequencer scans and compacts the tag ram.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_value_unit #(
   parameter int DEPTH     = 16,
   parameter int TAG_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fwd_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] tag_in
   input  logic [fwd_pkg::KIND_WIDTH-1:0]  req_tuser,  // [1:0] kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fwd_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] tag_out, [36:32] count
   output logic                            rsp_tuser   // [0] status
);

   import fwd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [TAG_WIDTH-1:0]  tag_ff, tag_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pend_status_ff, pend_status_in;
   logic [TAG_WIDTH-1:0]  pend_tag_ff, pend_tag_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [TAG_IO_WIDTH-1:0] rsp_tag_ff, rsp_tag_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [TAG_WIDTH-1:0]  wr_data, rd_data;

   logic [63:0]           req_tag_wide;
   logic [63:0]           pend_tag_wide;
   logic [31:0]           occ_wide;
   logic [CW-1:0]         idx_next;
   logic                  accept, slot_free, tag_hit;

   assign accept        = req_tvalid & req_tready;
   assign slot_free     = ~rsp_valid_ff | rsp_tready;
   assign req_tag_wide  = 64'(req_tdata[TAG_IO_WIDTH-1:0]);
   assign pend_tag_wide = 64'(pend_tag_ff);
   assign occ_wide      = 32'(occ_ff);
   assign idx_next      = idx_ff + CW'(1);
   assign tag_hit       = (rd_data == tag_ff);
   assign req_tready    = (state_ff == ST_IDLE);

   fwd_tag_ram #(
      .DEPTH (DEPTH),
      .WIDTH (TAG_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      tag_in         = tag_ff;
      occ_in         = occ_ff;
      idx_in         = idx_ff;
      pend_status_in = pend_status_ff;
      pend_tag_in    = pend_tag_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[AW-1:0];
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = idx_next[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = kind_type'(req_tuser);
               tag_in   = req_tag_wide[TAG_WIDTH-1:0];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            pend_status_in = STATUS_REJECT;
            pend_tag_in    = '0;
            idx_in         = '0;
            state_in       = ST_DONE;
            case (kind_ff)
               KIND_ENQUEUE: begin
                  if (tag_ff != '0 && occ_ff < CW'(DEPTH)) begin
                     wr_en          = 1'b1;
                     wr_addr        = occ_ff[AW-1:0];
                     wr_data        = tag_ff;
                     occ_in         = occ_ff + CW'(1);
                     pend_status_in = STATUS_OK;
                  end
               end
               KIND_DEQUEUE: begin
                  if (occ_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_FRONT;
                  end
               end
               KIND_DELETE: begin
                  if (tag_ff != '0 && occ_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FRONT: begin
            pend_tag_in = rd_data;
            state_in    = ST_SHIFT_RD;
         end
         ST_SCAN: begin
            // rd_data holds the entry at idx_ff
            if (tag_hit) begin
               state_in = ST_SHIFT_RD;
            end else if (idx_next == occ_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_next;
            end
         end
         ST_SHIFT_RD: begin
            if (idx_next < occ_ff) begin
               rd_en    = 1'b1;
               state_in = ST_SHIFT_WR;
            end else begin
               occ_in         = occ_ff - CW'(1);
               pend_status_in = STATUS_OK;
               state_in       = ST_DONE;
            end
         end
         ST_SHIFT_WR: begin
            // move the entry above down one slot
            wr_en    = 1'b1;
            idx_in   = idx_next;
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_tag_in    = (pend_status_ff == STATUS_OK) ?
                               pend_tag_wide[TAG_IO_WIDTH-1:0] : '0;
               rsp_count_in  = occ_wide[COUNT_WIDTH-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      tag_ff         <= tag_in;
      idx_ff         <= idx_in;
      pend_status_ff <= pend_status_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_tag_ff};

   // queue never holds more than its depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   // ram writes stay at or below the fill level
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= occ_ff))
      else $error("ram write beyond fill level");

   // a rejected beat carries a zero tag
   a_reject_tag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && slot_free && pend_status_ff == STATUS_REJECT)
      |=> (rsp_tvalid && rsp_tdata[TAG_IO_WIDTH-1:0] == '0))
      else $error("rejected result with nonzero tag");

   // a successful delete shrinks the queue by one
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD && kind_ff == KIND_DELETE && !(idx_next < occ_ff))
      |=> (occ_ff == $past(occ_ff) - CW'(1)))
      else $error("delete did not decrement count");

endmodule

[verif/fifo_with_delete_by_value_unit_test.sv]
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value_unit_test
// Self-checking bench for the ordered tag queue: a directed table walks the
// empty, null, full and unknown-kind corners plus front, middle and back
// deletes, then random traffic of all four kinds with idle gaps on both
// streams is scored beat by beat against a behavioral queue.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_value_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fwd_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_OPS   = 750;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_LIMIT   = 4000;

   typedef struct packed {
      logic                     status;
      logic [TAG_IO_WIDTH-1:0]  tag_out;
      logic [COUNT_WIDTH-1:0]   count;
   } queue_result_t;

   typedef struct {
      kind_type                 kind;
      logic [TAG_IO_WIDTH-1:0]  tag;
      int                       reps;     // tag steps by one per repeat
      bit                       typed;
      queue_result_t            want;
   } plan_row_t;

   localparam queue_result_t NONE = '0;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] tag_in
   logic [KIND_WIDTH-1:0]  req_tuser  = '0;   // [1:0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] tag_out, [36:32] count
   logic                   rsp_tuser;         // [0] status

   logic [TAG_IO_WIDTH-1:0] held_tags [$];
   queue_result_t           pending_results [$];

   int  errors = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;
   int  kind_seen [4] = '{0, 0, 0, 0};
   int  rejects = 0;
   int  full_hits = 0;
   int  empty_hits = 0;
   int  delete_hits = 0;

   plan_row_t directed_plan [] = '{
      '{KIND_DEQUEUE, 32'h0000_0000,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_DELETE,  32'h0000_0005,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_ENQUEUE, 32'h0000_0000,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_DELETE,  32'h0000_0000,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_UNUSED,  32'h0000_1234,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_ENQUEUE, 32'hFFFF_FFFF,  1, 1'b1, '{STATUS_OK,     32'h0, 5'd1}},
      '{KIND_ENQUEUE, 32'h0000_0001,  1, 1'b1, '{STATUS_OK,     32'h0, 5'd2}},
      '{KIND_ENQUEUE, 32'hA5A5_A5A5,  1, 1'b0, NONE},
      '{KIND_ENQUEUE, 32'h0000_0001,  1, 1'b0, NONE},
      '{KIND_DELETE,  32'h0000_0001,  1, 1'b0, NONE},
      '{KIND_DELETE,  32'h1234_5678,  1, 1'b0, NONE},
      '{KIND_DEQUEUE, 32'hDEAD_BEEF,  1, 1'b0, NONE},
      '{KIND_ENQUEUE, 32'h0000_0100, 14, 1'b0, NONE},
      '{KIND_ENQUEUE, 32'h0000_0077,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd16}},
      '{KIND_UNUSED,  32'hFFFF_FFFF,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd16}},
      '{KIND_DELETE,  32'h0000_010D,  1, 1'b0, NONE},
      '{KIND_DELETE,  32'hA5A5_A5A5,  1, 1'b0, NONE},
      '{KIND_DELETE,  32'h0000_0107,  1, 1'b0, NONE},
      '{KIND_ENQUEUE, 32'h8000_0000,  1, 1'b0, NONE},
      '{KIND_DEQUEUE, 32'h0000_0000, 14, 1'b0, NONE},
      '{KIND_DEQUEUE, 32'h5555_AAAA,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}},
      '{KIND_DELETE,  32'h8000_0000,  1, 1'b1, '{STATUS_REJECT, 32'h0, 5'd0}}
   };

   fifo_with_delete_by_value_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // behavioral queue: applies one operation and returns what the block reports
   function automatic queue_result_t queue_apply(input kind_type kind,
                                                 input logic [TAG_IO_WIDTH-1:0] tag);
      queue_result_t res;
      bit            ok;
      int            hit;
      ok  = 1'b0;
      hit = -1;
      res = '0;
      case (kind)
         KIND_ENQUEUE: begin
            if (held_tags.size() >= QUEUE_DEPTH) full_hits++;
            if (tag != '0 && held_tags.size() < QUEUE_DEPTH) begin
               held_tags.push_back(tag);
               ok = 1'b1;
            end
         end
         KIND_DEQUEUE: begin
            if (held_tags.size() == 0) begin
               empty_hits++;
            end else begin
               res.tag_out = held_tags.pop_front();
               ok = 1'b1;
            end
         end
         KIND_DELETE: begin
            if (tag != '0) begin
               foreach (held_tags[i]) begin
                  if (hit < 0 && held_tags[i] == tag) hit = i;
               end
            end
            if (hit >= 0) begin
               held_tags.delete(hit);
               delete_hits++;
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      if (!ok) rejects++;
      kind_seen[kind]++;
      res.status = ok ? STATUS_OK : STATUS_REJECT;
      res.count  = COUNT_WIDTH'(held_tags.size());
      return res;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_op(input kind_type kind, input logic [TAG_IO_WIDTH-1:0] tag,
                          input bit typed, input queue_result_t want);
      int            gap;
      queue_result_t predicted;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= KIND_WIDTH'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= tag;
      predicted = queue_apply(kind, tag);
      pending_results.push_back(typed ? want : predicted);
      do @(posedge clock); while (!req_tready);
   endtask

   // pick a random operation shaped by the current fill direction
   task automatic send_random(input int lean);
      int                      r;
      int                      enq_share;
      kind_type                kind;
      logic [TAG_IO_WIDTH-1:0] tag;
      r = $urandom_range(0, 99);
      enq_share = (lean == 0) ? 60 : (lean == 1) ? 20 : 40;
      if (r < 4)                          kind = KIND_UNUSED;
      else if (r < 4 + enq_share)         kind = KIND_ENQUEUE;
      else if (r < 4 + enq_share + 25)    kind = KIND_DELETE;
      else                                kind = KIND_DEQUEUE;
      r = $urandom_range(0, 99);
      tag = $urandom;
      if (kind == KIND_ENQUEUE) begin
         if (r < 5)       tag = '0;
         else if (r < 40) tag = $urandom_range(1, 8);   // duplicates for delete
      end else if (kind == KIND_DELETE) begin
         if (r < 5)
            tag = '0;
         else if (r < 70 && held_tags.size() > 0)
            tag = held_tags[$urandom_range(0, held_tags.size() - 1)];
         else if (r < 85)
            tag = $urandom_range(1, 8);
      end
      send_op(kind, tag, 1'b0, NONE);
   endtask

   // result side stalls
   always @(negedge clock) begin
      int r;
      if ($urandom_range(0, 199) == 0) recv_calm = ~recv_calm;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!recv_calm) begin
            r = $urandom_range(0, 99);
            if (r < 60)      stall_left = 0;
            else if (r < 92) stall_left = $urandom_range(1, 3);
            else             stall_left = $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      queue_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.tag_out) begin
               $error("tag_out: expected %h, got %h", want.tag_out, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[36:32] !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_tdata[36:32]);
               errors++;
            end
            if (rsp_tdata[39:37] !== 3'b000) begin
               $error("tdata pad: expected 0, got %b", rsp_tdata[39:37]);
               errors++;
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("no handshake for %0d cycles", IDLE_LIMIT);
         $display("fifo_with_delete_by_value_unit verification failed");
         $finish;
      end
   end

   initial begin
      int lean;
      lean = 2;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[n]) begin
         for (int k = 0; k < directed_plan[n].reps; k++) begin
            send_op(directed_plan[n].kind, directed_plan[n].tag + k,
                    directed_plan[n].typed, directed_plan[n].want);
         end
      end

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 60 == 0) lean = $urandom_range(0, 2);
         if (n % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
         send_random(lean);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ops: %0d enqueue, %0d dequeue, %0d delete, %0d unknown kind; %0d rejected",
               kind_seen[KIND_ENQUEUE], kind_seen[KIND_DEQUEUE],
               kind_seen[KIND_DELETE], kind_seen[KIND_UNUSED], rejects);
      $display("enqueue on full %0d, dequeue on empty %0d, delete hits %0d",
               full_hits, empty_hits, delete_hits);
      if (errors == 0)
         $display("fifo_with_delete_by_value_unit verification clean");
      else
         $display("fifo_with_delete_by_value_unit verification failed");
      $finish;
   end

endmodule
